/* hdl/brfps_pkg.sv */
// ----------------------------------------------------------------------------
// brfps_pkg
// shared constants, command codes and types of the byte ring fifo
// ----------------------------------------------------------------------------
package brfps_pkg;

    localparam int DEPTH_DEFAULT = 1024;

    localparam int CMD_W    = 2;
    localparam int DATA_W   = 8;
    localparam int OFFSET_W = 16;
    localparam int FIELD_W  = 10;

    localparam logic [CMD_W-1:0] CMD_PUT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GET  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SKIP = 2'd3;

    typedef struct packed {
        logic               ok;
        logic               rd_en;
        logic [FIELD_W-1:0] bytes_held;
        logic [FIELD_W-1:0] free_slots;
        logic [FIELD_W-1:0] skipped;
        logic [FIELD_W-1:0] contiguous_run;
    } ptr_res_t;

endpackage

/* hdl/brfps_if.sv */
// ----------------------------------------------------------------------------
// brfps_if
// command and result channels of the byte ring fifo
// ----------------------------------------------------------------------------
interface brfps_in_if
    import brfps_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [DATA_W-1:0]   data_byte;
    logic [OFFSET_W-1:0] peek_offset;
    logic [OFFSET_W-1:0] skip_count;

    modport source (
        output valid,
        output command,
        output data_byte,
        output peek_offset,
        output skip_count,
        input  ready
    );

    modport sink (
        input  valid,
        input  command,
        input  data_byte,
        input  peek_offset,
        input  skip_count,
        output ready
    );
endinterface

interface brfps_out_if
    import brfps_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               ok;
    logic [DATA_W-1:0]  read_byte;
    logic [FIELD_W-1:0] bytes_held;
    logic [FIELD_W-1:0] free_slots;
    logic [FIELD_W-1:0] skipped;
    logic [FIELD_W-1:0] contiguous_run;

    modport source (
        output valid,
        output ok,
        output read_byte,
        output bytes_held,
        output free_slots,
        output skipped,
        output contiguous_run,
        input  ready
    );

    modport sink (
        input  valid,
        input  ok,
        input  read_byte,
        input  bytes_held,
        input  free_slots,
        input  skipped,
        input  contiguous_run,
        output ready
    );
endinterface

/* hdl/brfps_mem.sv */
// ----------------------------------------------------------------------------
// brfps_mem
// single port byte store, registered read
// ----------------------------------------------------------------------------
module brfps_mem
    import brfps_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic              re,
    input  logic [AW-1:0]     addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] store_mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[addr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= store_mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/brfps_ptr.sv */
// ----------------------------------------------------------------------------
// brfps_ptr
// read and write pointers, fill level, run length and store access
// ----------------------------------------------------------------------------
module brfps_ptr
    import brfps_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                go,
    input  logic [CMD_W-1:0]    command,
    input  logic [OFFSET_W-1:0] peek_offset,
    input  logic [OFFSET_W-1:0] skip_count,
    output ptr_res_t            res,
    output logic                mem_we,
    output logic                mem_re,
    output logic [AW-1:0]       mem_addr
);

    localparam logic [AW:0] DEPTH_EXT = (AW+1)'(DEPTH);

    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;

    logic [AW-1:0] held;
    logic [AW-1:0] held_after;
    logic [AW-1:0] start;
    logic [AW-1:0] remaining;
    logic [AW-1:0] skip_amt;
    logic [AW:0]   to_end;
    logic [AW:0]   run;
    logic          off_lt;
    logic          full;
    logic          empty;
    logic          ok;
    logic          rd_en;

    always_comb
    begin
        held      = wr_ptr_reg - rd_ptr_reg;
        off_lt    = peek_offset < OFFSET_W'(held);
        start     = rd_ptr_reg + peek_offset[AW-1:0];
        to_end    = DEPTH_EXT - {1'b0, start};
        remaining = held - peek_offset[AW-1:0];
        full      = (wr_ptr_reg + AW'(1)) == rd_ptr_reg;
        empty     = held == '0;
        skip_amt  = (skip_count > OFFSET_W'(held)) ? held : skip_count[AW-1:0];

        if (!off_lt)
        begin
            run = '0;
        end
        else if (to_end < {1'b0, remaining})
        begin
            run = to_end;
        end
        else
        begin
            run = {1'b0, remaining};
        end

        ok          = 1'b0;
        rd_en       = 1'b0;
        held_after  = held;
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        mem_addr    = rd_ptr_reg;

        case (command)
            CMD_PUT:
            begin
                mem_addr = wr_ptr_reg;
                if (!full)
                begin
                    ok          = 1'b1;
                    held_after  = held + AW'(1);
                    wr_ptr_next = wr_ptr_reg + AW'(1);
                end
            end
            CMD_GET:
            begin
                if (!empty)
                begin
                    ok          = 1'b1;
                    rd_en       = 1'b1;
                    held_after  = held - AW'(1);
                    rd_ptr_next = rd_ptr_reg + AW'(1);
                end
            end
            CMD_PEEK:
            begin
                mem_addr = start;
                if (off_lt)
                begin
                    ok    = 1'b1;
                    rd_en = 1'b1;
                end
            end
            default:
            begin
                ok          = 1'b1;
                held_after  = held - skip_amt;
                rd_ptr_next = rd_ptr_reg + skip_amt;
            end
        endcase

        mem_we = go && (command == CMD_PUT) && ok;
        mem_re = go && rd_en;

        res.ok             = ok;
        res.rd_en          = rd_en;
        res.bytes_held     = FIELD_W'(held_after);
        res.free_slots     = FIELD_W'(~held_after);
        res.skipped        = (command == CMD_SKIP) ? FIELD_W'(skip_amt) : '0;
        res.contiguous_run = FIELD_W'(run);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
        end
        else if (go)
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
        end
    end

endmodule

/* hdl/byte_ring_fifo_peek_skip.sv */
// ----------------------------------------------------------------------------
// byte_ring_fifo_peek_skip
// byte fifo with put, get, peek and skip commands in a circular store
// ----------------------------------------------------------------------------
// The fifo keeps its bytes in a store of DEPTH entries (a power of two) and
// holds at most DEPTH-1 of them. For each command transfer the pointers update
// and the store is written or read when the command is taken; then the
// registered store read comes back and the result is loaded in the read state.
// The control waits out that store read before it takes the next command, so
// it takes no new command while a transfer is still in flight. A new command
// is taken in the cycle its predecessor's result is taken or once the result
// register is empty. No clearing pass is needed after reset.
module byte_ring_fifo_peek_skip
    import brfps_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    brfps_in_if.sink     req,
    brfps_out_if.source  rsp
);

    localparam int AW = $clog2(DEPTH);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    ptr_res_t pend_reg;
    ptr_res_t out_reg;
    logic [DATA_W-1:0] out_byte_reg;

    ptr_res_t          res;
    logic              accept;
    logic              mem_we;
    logic              mem_re;
    logic [AW-1:0]     mem_addr;
    logic [DATA_W-1:0] mem_rdata;

    assign req.ready = (state_reg == ST_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;

    brfps_ptr #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ptr (
        .clk         (clk),
        .rst_n       (rst_n),
        .go          (accept),
        .command     (req.command),
        .peek_offset (req.peek_offset),
        .skip_count  (req.skip_count),
        .res         (res),
        .mem_we      (mem_we),
        .mem_re      (mem_re),
        .mem_addr    (mem_addr)
    );

    brfps_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (req.data_byte),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next     = ST_IDLE;
                out_valid_next = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_reg <= res;
        end
        if (state_reg == ST_READ)
        begin
            out_reg      <= pend_reg;
            out_byte_reg <= pend_reg.rd_en ? mem_rdata : '0;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.ok             = out_reg.ok;
    assign rsp.read_byte      = out_byte_reg;
    assign rsp.bytes_held     = out_reg.bytes_held;
    assign rsp.free_slots     = out_reg.free_slots;
    assign rsp.skipped        = out_reg.skipped;
    assign rsp.contiguous_run = out_reg.contiguous_run;

`ifndef NO_ASSERTIONS
    a_accept_to_read: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_READ)
        else $error("transfer not followed by store read cycle");

    a_read_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ |=> out_valid_reg && state_reg == ST_IDLE)
        else $error("result not loaded after store read");

    a_mem_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we || mem_re) |-> accept)
        else $error("store access without transfer");

    a_fail_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.rd_en) |-> out_byte_reg == '0)
        else $error("read byte nonzero without store read");
`endif

endmodule
